### sv/frx_pkg.sv
// Shared types and constants of the frame receiver with XOR check.
`default_nettype none

package frx_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_SHORT_FLAG  = 2'd0;
    localparam logic [1:0] REG_LONG_FLAG   = 2'd1;
    localparam logic [1:0] REG_LONG_ENABLE = 2'd2;
    localparam logic [1:0] REG_BUFFER_SIZE = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_SHORT_FLAG  = 8'd165;
    localparam logic [7:0]  RST_LONG_FLAG   = 8'd168;
    localparam logic        RST_LONG_ENABLE = 1'b1;
    localparam logic [15:0] RST_BUFFER_SIZE = 16'd1024;

    // Header length (flag plus length field) of short and long frames.
    localparam logic [16:0] HDR_SHORT = 17'd2;
    localparam logic [16:0] HDR_LONG  = 17'd3;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN    = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_FIRST  = 3'd3,
        PH_BODY   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        KIND_DROP  = 3'd0,
        KIND_FLAG  = 3'd1,
        KIND_LEN   = 3'd2,
        KIND_CMD   = 3'd3,
        KIND_DATA  = 3'd4,
        KIND_CSUM  = 3'd5
    } t_kind;

    typedef struct packed {
        logic [7:0]  short_flag;
        logic [7:0]  long_flag;
        logic        long_enable;
        logic [15:0] buffer_size;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [16:0] position;
        logic [7:0]  running_xor;
        logic        long_kind;
        logic [15:0] length_value;
        logic        err_sync;
        logic        err_over;
        logic        err_sum;
        logic        pending;
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic [16:0] index;
        logic        done;
        logic        frame_long;
        logic [15:0] frame_length;
        logic        sync_error;
        logic        overflow_error;
        logic        checksum_error;
        logic        packet_pending;
    } t_result;

endpackage

`default_nettype wire

### sv/frx_cfg.sv
// Configuration registers of the frame receiver.
`default_nettype none

module frx_cfg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire  [1:0]       i_cfg_addr,
    input  wire  [15:0]      i_cfg_data,
    output frx_pkg::t_cfg    o_cfg
);
    import frx_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_flag  <= RST_SHORT_FLAG;
            r_cfg.long_flag   <= RST_LONG_FLAG;
            r_cfg.long_enable <= RST_LONG_ENABLE;
            r_cfg.buffer_size <= RST_BUFFER_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SHORT_FLAG:  r_cfg.short_flag  <= i_cfg_data[7:0];
                REG_LONG_FLAG:   r_cfg.long_flag   <= i_cfg_data[7:0];
                REG_LONG_ENABLE: r_cfg.long_enable <= i_cfg_data[0];
                REG_BUFFER_SIZE: r_cfg.buffer_size <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### sv/frx_parse.sv
// Next-state and result logic for one received item.
`default_nettype none

module frx_parse (
    input  frx_pkg::t_cfg    i_cfg,
    input  frx_pkg::t_state  i_state,
    input  wire              i_command,
    input  wire  [7:0]       i_byte,
    output frx_pkg::t_state  o_state,
    output frx_pkg::t_result o_result
);
    import frx_pkg::*;

    t_state      n_state;
    t_kind       kind;
    logic [16:0] index;
    logic        done;
    logic        accept;
    logic        is_long;
    logic [16:0] hdr;
    logic [17:0] frame_end;
    logic [17:0] end_check;

    assign is_long   = i_cfg.long_enable && (i_byte == i_cfg.long_flag);
    assign hdr       = i_state.long_kind ? HDR_LONG : HDR_SHORT;
    // Length plus position, compared against the buffer size for overflow.
    assign frame_end = {2'b00, i_state.length_value} + {1'b0, i_state.position};
    // Position at which the checksum byte is expected.
    assign end_check = {2'b00, i_state.length_value} + {1'b0, hdr};

    always_comb begin
        n_state = i_state;
        kind    = KIND_DROP;
        index   = '0;
        done    = 1'b0;
        accept  = 1'b0;

        if (i_command) begin
            n_state = '0;
        end else if (i_state.pending) begin
            n_state.err_sync = 1'b1;
            index            = i_state.position;
        end else begin
            index = i_state.position;
            if (i_state.position == '0) begin
                if (is_long || (i_byte == i_cfg.short_flag)) begin
                    n_state.running_xor  = '0;
                    n_state.long_kind    = is_long;
                    n_state.length_value = '0;
                    n_state.phase        = PH_LEN;
                    kind                 = KIND_FLAG;
                    accept               = 1'b1;
                end else begin
                    n_state.err_sync = 1'b1;
                end
            end else begin
                case (i_state.phase)
                    PH_LEN: begin
                        n_state.length_value = {8'h00, i_byte};
                        n_state.phase        = i_state.long_kind ? PH_LEN_HI : PH_FIRST;
                        kind                 = KIND_LEN;
                        accept               = 1'b1;
                    end
                    PH_LEN_HI: begin
                        n_state.length_value = {i_byte, i_state.length_value[7:0]};
                        n_state.phase        = PH_FIRST;
                        kind                 = KIND_LEN;
                        accept               = 1'b1;
                    end
                    PH_FIRST, PH_BODY: begin
                        if ((i_state.phase == PH_FIRST) &&
                            (frame_end > {2'b00, i_cfg.buffer_size})) begin
                            n_state.err_over = 1'b1;
                            n_state.position = '0;
                            n_state.phase    = PH_HUNT;
                        end else if ({1'b0, i_state.position} == end_check) begin
                            if (i_byte != i_state.running_xor) begin
                                n_state.err_sum = 1'b1;
                            end
                            n_state.pending  = 1'b1;
                            n_state.position = '0;
                            n_state.phase    = PH_HUNT;
                            kind             = KIND_CSUM;
                            done             = 1'b1;
                        end else begin
                            n_state.phase = PH_BODY;
                            kind          = (i_state.phase == PH_FIRST) ? KIND_CMD : KIND_DATA;
                            accept        = 1'b1;
                        end
                    end
                    default: begin
                        // Stray phase code: drop the byte and start hunting again.
                        n_state.position = '0;
                        n_state.phase    = PH_HUNT;
                    end
                endcase
            end
            if (accept) begin
                n_state.running_xor = n_state.running_xor ^ i_byte;
                n_state.position    = n_state.position + 17'd1;
            end
        end
    end

    assign o_state = n_state;

    always_comb begin
        o_result.kind           = kind;
        o_result.value          = i_command ? 8'h00 : i_byte;
        o_result.index          = index;
        o_result.done           = done;
        o_result.frame_long     = n_state.long_kind;
        o_result.frame_length   = n_state.length_value;
        o_result.sync_error     = n_state.err_sync;
        o_result.overflow_error = n_state.err_over;
        o_result.checksum_error = n_state.err_sum;
        o_result.packet_pending = n_state.pending;
    end

endmodule

`default_nettype wire

### sv/frame_receiver_xor_check.sv
// Top level of the byte-serial frame receiver with XOR checksum check.
// An accepted item is held in the input register and moves on into the result
// register when that register is free or being drained; its result is offered
// from there. Throughput: one item per cycle while the result stream is not
// stalled; the frame state updates in a single pass from the input register to
// the result register.
// Reset (synchronous, active low) clears the frame state, the errors, the
// pending mark and both valid bits, and restores the register defaults.
`default_nettype none

module frame_receiver_xor_check (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write port.
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [15:0] i_cfg_data,
    // Input stream.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tuser,   // [0] command
    // Result stream.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] byte_value, [24:8] byte_index, [25] frame_long,
    // [41:26] frame_length, [42] sync_error, [43] overflow_error,
    // [44] checksum_error, [45] packet_pending, [47:46] zero
    output logic [47:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] byte_kind
    output logic        m_axis_tlast    // frame_done
);
    import frx_pkg::*;

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;

    logic       r_in_valid;
    logic       r_in_cmd;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       advance;

    frx_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The buffered item moves into the result register whenever that register
    // is empty or is being drained in the same cycle.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    frx_parse u_parse (
        .i_cfg     (cfg),
        .i_state   (r_state),
        .i_command (r_in_cmd),
        .i_byte    (r_in_byte),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // Frame state commits together with the result it produced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_result.kind;
    assign m_axis_tlast  = r_result.done;
    assign m_axis_tdata  = {2'b00,
                            r_result.packet_pending,
                            r_result.checksum_error,
                            r_result.overflow_error,
                            r_result.sync_error,
                            r_result.frame_length,
                            r_result.frame_long,
                            r_result.index,
                            r_result.value};

endmodule

`default_nettype wire

### sv/frx_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
`default_nettype none

module frx_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata,
    input wire [2:0]  m_axis_tuser,
    input wire        m_axis_tlast
);
    import frx_pkg::*;

    // A frame ends exactly on its checksum item.
    a_last_is_csum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_CSUM)
        else $error("frame end on an item that is not a checksum");

    a_csum_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_CSUM) |-> m_axis_tlast)
        else $error("checksum item without frame end");

    // A completed frame is always left pending.
    a_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[45])
        else $error("frame end without pending packet");

    // A start flag always sits at the head of the frame.
    a_flag_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_FLAG) |-> m_axis_tdata[24:8] == 17'd0)
        else $error("flag item at nonzero position");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind frame_receiver_xor_check frx_checker u_frx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### verif/frx_report_checker.sv
// Byte report checker: predicts each report of the frame receiver and compares it.
`timescale 1ns / 100ps

module frx_report_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_in_tvalid,
    input  wire         i_in_tready,
    input  wire  [7:0]  i_in_tdata,
    input  wire         i_in_tuser,
    input  wire         i_out_tvalid,
    input  wire         i_out_tready,
    input  wire  [47:0] i_out_tdata,
    input  wire  [2:0]  i_out_tuser,
    input  wire         i_out_tlast,
    output int          o_mismatch_count,
    output int          o_awaited_count
);
    import frx_pkg::*;

    t_cfg    rx_cfg;
    t_state  rx_st;
    t_result awaited_reports[$];
    t_result want;

    initial begin
        o_mismatch_count = 0;
        o_awaited_count  = 0;
    end

    // Own copy of the deframer: classifies one byte or command and updates rx_st.
    function automatic t_result classify_byte(input logic cmd, input logic [7:0] b);
        t_result     r;
        logic [16:0] hdr;
        logic        is_long;
        logic        accept;
        logic        was_first;
        int          span;
        int          frame_end;
        r        = '0;
        r.kind   = KIND_DROP;
        r.value  = b;
        accept   = 1'b0;
        if (cmd) begin
            rx_st.phase        = PH_HUNT;
            rx_st.position     = '0;
            rx_st.running_xor  = '0;
            rx_st.long_kind    = 1'b0;
            rx_st.length_value = '0;
            rx_st.err_sync     = 1'b0;
            rx_st.err_over     = 1'b0;
            rx_st.err_sum      = 1'b0;
            rx_st.pending      = 1'b0;
            r.value            = '0;
        end else if (rx_st.pending) begin
            rx_st.err_sync = 1'b1;
            r.index        = rx_st.position;
        end else begin
            hdr     = rx_st.long_kind ? HDR_LONG : HDR_SHORT;
            r.index = rx_st.position;
            if (rx_st.position == '0) begin
                is_long = rx_cfg.long_enable && (b == rx_cfg.long_flag);
                if (is_long || b == rx_cfg.short_flag) begin
                    rx_st.running_xor  = '0;
                    rx_st.long_kind    = is_long;
                    rx_st.length_value = '0;
                    rx_st.phase        = PH_LEN;
                    r.kind             = KIND_FLAG;
                    accept             = 1'b1;
                end else begin
                    rx_st.err_sync = 1'b1;
                end
            end else if (rx_st.phase == PH_LEN) begin
                rx_st.length_value = {8'h00, b};
                rx_st.phase        = rx_st.long_kind ? PH_LEN_HI : PH_FIRST;
                r.kind             = KIND_LEN;
                accept             = 1'b1;
            end else if (rx_st.phase == PH_LEN_HI) begin
                rx_st.length_value = {b, rx_st.length_value[7:0]};
                rx_st.phase        = PH_FIRST;
                r.kind             = KIND_LEN;
                accept             = 1'b1;
            end else if (rx_st.phase == PH_FIRST || rx_st.phase == PH_BODY) begin
                span      = rx_st.length_value + rx_st.position;
                frame_end = rx_st.length_value + hdr;
                if (rx_st.phase == PH_FIRST && span > rx_cfg.buffer_size) begin
                    rx_st.err_over = 1'b1;
                    rx_st.position = '0;
                    rx_st.phase    = PH_HUNT;
                end else begin
                    was_first   = (rx_st.phase == PH_FIRST);
                    rx_st.phase = PH_BODY;
                    if (rx_st.position == frame_end) begin
                        // Closing byte: compare against the running XOR.
                        if (b != rx_st.running_xor) rx_st.err_sum = 1'b1;
                        rx_st.pending  = 1'b1;
                        rx_st.position = '0;
                        rx_st.phase    = PH_HUNT;
                        r.kind         = KIND_CSUM;
                        r.done         = 1'b1;
                    end else begin
                        r.kind = was_first ? KIND_CMD : KIND_DATA;
                        accept = 1'b1;
                    end
                end
            end else begin
                rx_st.position = '0;
                rx_st.phase    = PH_HUNT;
            end
            if (accept) begin
                rx_st.running_xor = rx_st.running_xor ^ b;
                rx_st.position    = rx_st.position + 17'd1;
            end
        end
        r.frame_long     = rx_st.long_kind;
        r.frame_length   = rx_st.length_value;
        r.sync_error     = rx_st.err_sync;
        r.overflow_error = rx_st.err_over;
        r.checksum_error = rx_st.err_sum;
        r.packet_pending = rx_st.pending;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            o_mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_cfg.short_flag  = RST_SHORT_FLAG;
            rx_cfg.long_flag   = RST_LONG_FLAG;
            rx_cfg.long_enable = RST_LONG_ENABLE;
            rx_cfg.buffer_size = RST_BUFFER_SIZE;
            void'(classify_byte(1'b1, 8'h00));
            awaited_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SHORT_FLAG:  rx_cfg.short_flag  = i_cfg_data[7:0];
                    REG_LONG_FLAG:   rx_cfg.long_flag   = i_cfg_data[7:0];
                    REG_LONG_ENABLE: rx_cfg.long_enable = i_cfg_data[0];
                    REG_BUFFER_SIZE: rx_cfg.buffer_size = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_tvalid && i_out_tready) begin
                if (awaited_reports.size() == 0) begin
                    $error("report with no byte awaiting it: tdata 0x%0h", i_out_tdata);
                    o_mismatch_count++;
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("byte_kind", 32'(want.kind), 32'(i_out_tuser));
                    check_field("byte_value", 32'(want.value), 32'(i_out_tdata[7:0]));
                    check_field("byte_index", 32'(want.index), 32'(i_out_tdata[24:8]));
                    check_field("frame_done", 32'(want.done), 32'(i_out_tlast));
                    check_field("frame_long", 32'(want.frame_long),
                                32'(i_out_tdata[25]));
                    check_field("frame_length", 32'(want.frame_length),
                                32'(i_out_tdata[41:26]));
                    check_field("sync_error", 32'(want.sync_error),
                                32'(i_out_tdata[42]));
                    check_field("overflow_error", 32'(want.overflow_error),
                                32'(i_out_tdata[43]));
                    check_field("checksum_error", 32'(want.checksum_error),
                                32'(i_out_tdata[44]));
                    check_field("packet_pending", 32'(want.packet_pending),
                                32'(i_out_tdata[45]));
                end
            end
            if (i_in_tvalid && i_in_tready)
                awaited_reports.push_back(classify_byte(i_in_tuser, i_in_tdata));
        end
        o_awaited_count <= awaited_reports.size();
    end

endmodule

### verif/tb_frame_receiver_xor_check.sv
// Top of the frame receiver regression: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_frame_receiver_xor_check;
    import frx_pkg::*;

    // The run is cut off here; a correct run needs a small fraction of it.
    localparam int CYCLE_LIMIT = 200000;

    // How the length of a generated frame is chosen.
    typedef enum int {
        LEN_SMALL,
        LEN_EDGE,
        LEN_OVER
    } t_len_mode;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [1:0]  cfg_addr    = '0;
    logic [15:0] cfg_data    = '0;
    logic        in_tvalid   = 1'b0;
    logic        in_tready;
    logic [7:0]  in_tdata    = '0;
    logic        in_tuser    = 1'b0;
    logic        out_tvalid;
    logic        out_tready  = 1'b0;
    logic [47:0] out_tdata;
    logic [2:0]  out_tuser;
    logic        out_tlast;

    int mismatch_count;
    int awaited_count;
    int cycle_count = 0;
    int items_sent  = 0;
    int src_idle    = 0;
    int dst_idle    = 0;

    // The stimulus keeps its own view of the register settings so that it can
    // build frames that the block will recognize.
    logic [7:0]  cur_short  = RST_SHORT_FLAG;
    logic [7:0]  cur_long   = RST_LONG_FLAG;
    logic        cur_long_en = RST_LONG_ENABLE;
    logic [15:0] cur_buf    = RST_BUFFER_SIZE;

    frame_receiver_xor_check dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (in_tvalid),
        .s_axis_tready (in_tready),
        .s_axis_tdata  (in_tdata),
        .s_axis_tuser  (in_tuser),
        .m_axis_tvalid (out_tvalid),
        .m_axis_tready (out_tready),
        .m_axis_tdata  (out_tdata),
        .m_axis_tuser  (out_tuser),
        .m_axis_tlast  (out_tlast)
    );

    frx_report_checker u_report_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_addr       (cfg_addr),
        .i_cfg_data       (cfg_data),
        .i_in_tvalid      (in_tvalid),
        .i_in_tready      (in_tready),
        .i_in_tdata       (in_tdata),
        .i_in_tuser       (in_tuser),
        .i_out_tvalid     (out_tvalid),
        .i_out_tready     (out_tready),
        .i_out_tdata      (out_tdata),
        .i_out_tuser      (out_tuser),
        .i_out_tlast      (out_tlast),
        .o_mismatch_count (mismatch_count),
        .o_awaited_count  (awaited_count)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake must not keep the run alive forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("frame_receiver_xor_check regression: fail");
            $finish;
        end
    end

    // The receiver stalls at random; the rate follows the current idling phase.
    always @(negedge i_clk) begin
        out_tready <= ($urandom_range(0, 99) >= dst_idle);
    end

    // Offers one item and returns at the falling edge after it was accepted.
    // The idling rates move through three phases as the run goes on: a busy
    // sender with a slow receiver, the reverse, and finally no gaps at all.
    task automatic push_item(input logic cmd, input logic [7:0] b);
        if (items_sent < 450) begin
            src_idle = 26;
            dst_idle = 82;
        end else if (items_sent < 900) begin
            src_idle = 82;
            dst_idle = 26;
        end else begin
            src_idle = 0;
            dst_idle = 0;
        end
        while ($urandom_range(0, 99) < src_idle) begin
            in_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        in_tvalid <= 1'b1;
        in_tdata  <= b;
        in_tuser  <= cmd;
        @(posedge i_clk);
        while (!in_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Builds one frame under the current settings and sends it. An oversized
    // frame is cut off after a couple of body bytes, since the block drops it
    // there anyway; a frame that is cut off gets no checksum.
    task automatic send_frame(input bit want_long, input t_len_mode mode, input bit bad_sum);
        logic [7:0]  flag;
        logic [7:0]  sum;
        logic [7:0]  x;
        logic [15:0] len_field;
        bit          is_long;
        int          hdr;
        int          cap;
        int          len;
        int          limit;
        int          top;
        int          lo;
        if (want_long && cur_long_en) begin
            flag    = cur_long;
            is_long = 1'b1;
        end else begin
            // With both flags equal and long frames enabled, the block reads
            // the short flag as a long one.
            flag    = cur_short;
            is_long = cur_long_en && (cur_short == cur_long);
        end
        hdr = is_long ? 3 : 2;
        top = is_long ? 65535 : 255;
        cap = int'(cur_buf) - hdr;
        len = $urandom_range(0, 8);
        if (mode == LEN_EDGE && cap >= 0 && cap <= 40) begin
            // A frame that just fits, or is one or two bytes short of full.
            len = cap - $urandom_range(0, (cap < 2) ? cap : 2);
        end else if (mode == LEN_OVER) begin
            if (cap >= 0) len = cap + 1 + $urandom_range(0, 3);
            lo = (cap < 0) ? 0 : cap + 1;
            if (is_long && lo <= 65535 && $urandom_range(0, 1)) len = $urandom_range(lo, 65535);
        end
        if (len > top) len = top;
        limit     = (mode == LEN_OVER) ? 2 : len;
        len_field = 16'(len);
        push_item(1'b0, flag);
        sum = flag;
        push_item(1'b0, len_field[7:0]);
        sum = sum ^ len_field[7:0];
        if (is_long) begin
            push_item(1'b0, len_field[15:8]);
            sum = sum ^ len_field[15:8];
        end
        for (int i = 0; i < len && i < limit; i++) begin
            x = 8'($urandom);
            push_item(1'b0, x);
            sum = sum ^ x;
        end
        if (len <= limit)
            push_item(1'b0, bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    endtask

    // Writes all four registers on consecutive edges. The upper bits of the
    // narrow registers carry junk, which the block must mask off.
    task automatic apply_settings(input logic [7:0] sf, input logic [7:0] lf,
                                  input logic en, input logic [15:0] bs);
        logic [31:0] junk;
        junk = $urandom;
        cfg_we   <= 1'b1;
        cfg_addr <= REG_SHORT_FLAG;
        cfg_data <= {junk[7:0], sf};
        @(negedge i_clk);
        cfg_addr <= REG_LONG_FLAG;
        cfg_data <= {junk[15:8], lf};
        @(negedge i_clk);
        cfg_addr <= REG_LONG_ENABLE;
        cfg_data <= {junk[30:16], en};
        @(negedge i_clk);
        cfg_addr <= REG_BUFFER_SIZE;
        cfg_data <= bs;
        @(negedge i_clk);
        cfg_we      <= 1'b0;
        cur_short   = sf;
        cur_long    = lf;
        cur_long_en = en;
        cur_buf     = bs;
        @(negedge i_clk);
    endtask

    // Random traffic: mostly whole frames closed by a release, with oversized
    // frames, stray bytes and bytes sent into a pending packet mixed in.
    task automatic run_traffic(input int quota);
        int start;
        int r;
        start = items_sent;
        while (items_sent - start < quota) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                send_frame(1'($urandom_range(0, 1)),
                           ($urandom_range(0, 3) == 0) ? LEN_EDGE : LEN_SMALL,
                           ($urandom_range(0, 6) == 0));
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 2)) push_item(1'b0, 8'($urandom));
                push_item(1'b1, 8'($urandom));
            end else if (r < 75) begin
                send_frame(1'($urandom_range(0, 1)), LEN_OVER, 1'b0);
                if ($urandom_range(0, 1)) push_item(1'b1, 8'($urandom));
            end else if (r < 90) begin
                repeat ($urandom_range(1, 4)) push_item(1'b0, 8'($urandom));
                if ($urandom_range(0, 1)) push_item(1'b1, 8'($urandom));
            end else begin
                push_item(1'b1, 8'($urandom));
            end
        end
    endtask

    // Registers change only once every report is in and the pipeline has
    // emptied; every item yields a report, so a short pause is enough. The
    // sender stops offering first so that the last item is not taken again.
    task automatic wait_drained();
        in_tvalid <= 1'b0;
        wait (awaited_count == 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset settings. A release as the first item
        // carries all ones in the data byte, which the block must not report.
        push_item(1'b1, 8'hFF);
        // A stray byte outside any frame raises the sync error.
        push_item(1'b0, 8'h00);
        push_item(1'b1, 8'h00);
        // Short frame with data bytes at both extremes and a good checksum,
        // then a byte that arrives while the packet is pending.
        push_item(1'b0, RST_SHORT_FLAG);
        push_item(1'b0, 8'h02);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'h58);
        push_item(1'b0, 8'h7E);
        push_item(1'b1, 8'h00);
        // Long frame with one command byte and a wrong checksum.
        push_item(1'b0, RST_LONG_FLAG);
        push_item(1'b0, 8'h01);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'h33);
        push_item(1'b0, 8'h9B);
        push_item(1'b1, 8'h00);
        // Zero length: the byte after the length field is the checksum.
        push_item(1'b0, RST_SHORT_FLAG);
        push_item(1'b0, 8'h00);
        push_item(1'b0, RST_SHORT_FLAG);
        push_item(1'b1, 8'h00);
        // Maximum long length overflows the buffer; hunting restarts, so the
        // next byte is a sync error.
        push_item(1'b0, RST_LONG_FLAG);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'h11);
        push_item(1'b0, 8'h22);
        push_item(1'b1, 8'h00);

        run_traffic(190);

        // Further settings: both flag extremes, long frames off, equal flags
        // either way, a buffer of one byte, of zero bytes and at its maximum.
        for (int p = 1; p <= 6; p++) begin
            wait_drained();
            case (p)
                1: apply_settings(8'h00, 8'hFF, 1'b1, 16'hFFFF);
                2: apply_settings(8'hFF, 8'h00, 1'b0, 16'd14);
                3: apply_settings(8'h5A, 8'h5A, 1'b1, 16'd9);
                4: apply_settings(8'h3C, 8'h3C, 1'b0, 16'd1);
                5: apply_settings(8'($urandom), 8'($urandom), 1'($urandom), 16'd0);
                default: apply_settings(8'($urandom), 8'($urandom), 1'b1,
                                        16'($urandom_range(4, 40)));
            endcase
            run_traffic(190);
        end

        in_tvalid <= 1'b0;
        wait (awaited_count == 0);
        repeat (6) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("frame_receiver_xor_check regression: pass");
        end else begin
            $display("frame_receiver_xor_check regression: fail");
        end
        $finish;
    end

endmodule

### files.f
sv/frx_pkg.sv
sv/frx_cfg.sv
sv/frx_parse.sv
sv/frame_receiver_xor_check.sv
sv/frx_checker.sv
verif/frx_report_checker.sv
verif/tb_frame_receiver_xor_check.sv
